@@ rtl/assert_macros.svh @@
// Assertion macros shared by the SPI flash command engine RTL.
// Clock clk_i and active-low reset rst_ni are taken from the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define SFCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SFCE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define SFCE_ASSERT(lbl, prop, msg)
`define SFCE_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

@@ rtl/sfce_pkg.sv @@
// Shared types, opcodes and constants of the SPI flash command engine.
// Used by sfce_store and spi_flash_command_engine; depends on nothing.
package sfce_pkg;

  localparam int unsigned PAGE_BYTES   = 256;
  localparam int unsigned PAGE_IDX_W   = 8;
  localparam int unsigned SECTOR_BYTES = 65536;
  localparam int unsigned SECTOR_SHIFT = 16;
  localparam int unsigned SECTOR_NUM_W = 9;

  // Item operation codes
  localparam logic [1:0] OP_SELECT  = 2'd0;
  localparam logic [1:0] OP_XFER    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Flash command opcodes
  localparam logic [7:0] OPC_WRSR = 8'h01;
  localparam logic [7:0] OPC_PP   = 8'h02;
  localparam logic [7:0] OPC_READ = 8'h03;
  localparam logic [7:0] OPC_WRDI = 8'h04;
  localparam logic [7:0] OPC_RDSR = 8'h05;
  localparam logic [7:0] OPC_WREN = 8'h06;
  localparam logic [7:0] OPC_FAST = 8'h0B;
  localparam logic [7:0] OPC_RDID = 8'h9F;
  localparam logic [7:0] OPC_RES  = 8'hAB;
  localparam logic [7:0] OPC_BE   = 8'hC7;
  localparam logic [7:0] OPC_SE   = 8'hD8;

  localparam logic [31:0] ID_WORD  = 32'h2020_1410;
  localparam logic [31:0] RES_WORD = 32'h1300_0000;

  // Block-protect codes from this value up cover every sector
  localparam logic [2:0] BP_ALL = 3'd5;

  typedef enum logic [2:0] {
    JOB_NONE         = 3'd0,
    JOB_READ         = 3'd1,
    JOB_ERASE_SECTOR = 3'd2,
    JOB_ERASE_ALL    = 3'd3,
    JOB_COMMIT       = 3'd4,
    JOB_PRESET       = 3'd5
  } job_e;

  typedef struct packed {
    logic                  en;
    logic [PAGE_IDX_W-1:0] idx;
    logic [7:0]            data;
  } buf_wr_t;

  typedef struct packed {
    logic       busy;
    logic       rd_valid;
    logic [7:0] rd_data;
  } store_resp_t;

  // Number of protected sectors at the top of the store for BP codes 1 to 4
  function automatic logic [SECTOR_NUM_W-1:0] bp_top(input logic [2:0] bp);
    logic [SECTOR_NUM_W-1:0] top;
    case (bp)
      3'd1:    top = SECTOR_NUM_W'(1);
      3'd2:    top = SECTOR_NUM_W'(2);
      3'd3:    top = SECTOR_NUM_W'(4);
      3'd4:    top = SECTOR_NUM_W'(8);
      default: top = '0;
    endcase
    return top;
  endfunction

endpackage

@@ rtl/sfce_store.sv @@
// Flash byte array, page buffer and the sweep sequencer that reads, erases and commits.
// Depends on sfce_pkg.
module sfce_store #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sfce_pkg::job_e         job_kind_i,
  input  logic [ADDR_BITS-1:0]   job_addr_i,
  input  sfce_pkg::buf_wr_t      buf_wr_i,
  output sfce_pkg::store_resp_t  resp_o
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;
  localparam int unsigned PW    = sfce_pkg::PAGE_IDX_W;
  localparam logic [ADDR_BITS-1:0] SEC_MASK  = ADDR_BITS'(sfce_pkg::SECTOR_BYTES - 1);
  localparam logic [ADDR_BITS-1:0] PAGE_MASK = ADDR_BITS'(sfce_pkg::PAGE_BYTES - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_ERASE  = 5'b00100,
    ST_CMT_RD = 5'b01000,
    ST_CMT_WR = 5'b10000
  } st_e;

  st_e                   state_q, state_d;
  logic [ADDR_BITS-1:0]  ptr_q, ptr_d;
  logic [ADDR_BITS-1:0]  mask_q, mask_d;
  logic [ADDR_BITS-1:0]  ptr_inc;
  logic                  sweep_last;

  logic [7:0]            mem [DEPTH];
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [ADDR_BITS-1:0]  mem_raddr;
  logic [7:0]            mem_wdata;
  logic [7:0]            mem_rdata_q;

  logic [7:0]            pb_mem [sfce_pkg::PAGE_BYTES];
  logic [sfce_pkg::PAGE_BYTES-1:0] pb_vld_q;
  logic [7:0]            pb_rdata_q;
  logic                  pb_rvld_q;
  logic                  pb_clr;

  // Single incrementer and end-of-range compare shared by every sweep
  assign ptr_inc    = ptr_q + ADDR_BITS'(1);
  assign sweep_last = (ptr_q & mask_q) == mask_q;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    mask_d    = mask_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = 8'hFF;
    mem_raddr = ptr_q;
    pb_clr    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        case (job_kind_i)
          sfce_pkg::JOB_READ: begin
            mem_raddr = job_addr_i;
            state_d   = ST_READ;
          end
          sfce_pkg::JOB_ERASE_SECTOR: begin
            ptr_d   = job_addr_i & ~SEC_MASK;
            mask_d  = SEC_MASK;
            state_d = ST_ERASE;
          end
          sfce_pkg::JOB_ERASE_ALL: begin
            ptr_d   = '0;
            mask_d  = '1;
            state_d = ST_ERASE;
          end
          sfce_pkg::JOB_COMMIT: begin
            ptr_d   = job_addr_i & ~PAGE_MASK;
            mask_d  = PAGE_MASK;
            state_d = ST_CMT_RD;
          end
          sfce_pkg::JOB_PRESET: pb_clr = 1'b1;
          default: ;
        endcase
      end
      ST_READ: state_d = ST_IDLE;
      ST_ERASE: begin
        mem_we = 1'b1;
        if (sweep_last) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      ST_CMT_RD: state_d = ST_CMT_WR;
      ST_CMT_WR: begin
        // Programming only clears bits: AND the buffered byte into the cell
        mem_we    = 1'b1;
        mem_wdata = mem_rdata_q & (pb_rvld_q ? pb_rdata_q : 8'hFF);
        if (sweep_last) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d   = ptr_inc;
          state_d = ST_CMT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ERASE;
      ptr_q   <= '0;
      mask_q  <= '1;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) begin
      pb_mem[buf_wr_i.idx] <= buf_wr_i.data;
    end
    pb_rdata_q <= pb_mem[ptr_q[PW-1:0]];
  end

  // Unwritten buffer entries read as erased
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_vld_q  <= '0;
      pb_rvld_q <= 1'b0;
    end else begin
      if (pb_clr) begin
        pb_vld_q <= '0;
      end else if (buf_wr_i.en) begin
        pb_vld_q[buf_wr_i.idx] <= 1'b1;
      end
      pb_rvld_q <= pb_vld_q[ptr_q[PW-1:0]];
    end
  end

  assign resp_o.busy     = state_q != ST_IDLE;
  assign resp_o.rd_valid = state_q == ST_READ;
  assign resp_o.rd_data  = mem_rdata_q;

endmodule

@@ rtl/spi_flash_command_engine.sv @@
// SPI NOR flash command engine: byte-level command decode, status and output queue.
// Depends on sfce_pkg, sfce_store and assert_macros.svh.
//
// Each input transfer is one bus event: chip select asserted, one byte exchanged, or
// chip select released; each gives exactly one result transfer carrying the byte
// shifted out, the status register and a flag for a refused page program. Select,
// release and most exchanges are decoded in the cycle they are accepted, and the
// result sits in an output register, so with the store idle and the result side not
// stalling one transfer is taken per cycle. Work on the flash array runs in the store
// sequencer, which owns the array's read and write ports, and holds off the next transfer
// while it works: an exchange that fetches a read byte, a page commit at release (a read
// and a write for each of the 256 bytes of the page), a sector erase and a bulk erase.
// Erases write one byte per cycle. After reset the store runs a clearing pass that writes
// every byte to 0xFF; no transfer is accepted until it finishes.
`include "assert_macros.svh"

module spi_flash_command_engine #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] mosi_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] miso_byte_o,
  output logic [7:0] status_byte_o,
  output logic       write_refused_o
);

  localparam int unsigned SNW = sfce_pkg::SECTOR_NUM_W;
  localparam int unsigned PW  = sfce_pkg::PAGE_IDX_W;
  localparam logic [SNW-1:0] SECTOR_COUNT =
    SNW'(1 << (ADDR_BITS - sfce_pkg::SECTOR_SHIFT));
  localparam logic [ADDR_BITS-1:0] PAGE_MASK = ADDR_BITS'(sfce_pkg::PAGE_BYTES - 1);

  // Command phase currently in progress
  typedef enum logic [7:0] {
    AC_IDLE  = 8'b0000_0001,
    AC_WRSR  = 8'b0000_0010,
    AC_READ  = 8'b0000_0100,
    AC_FAST  = 8'b0000_1000,
    AC_RDATA = 8'b0001_0000,
    AC_PP    = 8'b0010_0000,
    AC_PDATA = 8'b0100_0000,
    AC_SE    = 8'b1000_0000
  } ac_e;

  ac_e                   ac_q, ac_d;
  logic                  wel_q, wel_d;
  logic [2:0]            bp_q, bp_d;
  logic [31:0]           oq_q, oq_d;
  logic [ADDR_BITS-1:0]  ins_q, ins_d;
  logic [1:0]            br_q, br_d;
  logic [ADDR_BITS-1:0]  ba_q, ba_d;
  logic [PW-1:0]         pi_q, pi_d;
  logic                  sel_q, sel_d;

  logic                  out_valid_q;
  logic [7:0]            miso_q;
  logic [7:0]            status_q;
  logic                  refused_q;

  logic                  accept;
  logic [ADDR_BITS-1:0]  ins_shift;
  logic [SNW-1:0]        sector_num;
  logic                  prot;
  logic [7:0]            status_now;
  logic [7:0]            miso;
  logic                  refused;

  sfce_pkg::job_e        job_kind;
  logic [ADDR_BITS-1:0]  job_addr;
  sfce_pkg::buf_wr_t     buf_wr;
  sfce_pkg::store_resp_t resp;

  // Hold off new transfers while the store is busy or the result is still waiting
  assign in_stall_o = resp.busy || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign status_now = {3'b000, bp_q, wel_q, 1'b0};
  assign ins_shift  = {ins_q[ADDR_BITS-9:0], mosi_byte_i};

  // Page program protection, checked against the incoming address
  assign sector_num = SNW'(ins_shift >> sfce_pkg::SECTOR_SHIFT);
  assign prot = (bp_q >= sfce_pkg::BP_ALL) ||
                ((sector_num + sfce_pkg::bp_top(bp_q)) >= SECTOR_COUNT);

  always_comb begin
    ac_d     = ac_q;
    wel_d    = wel_q;
    bp_d     = bp_q;
    oq_d     = oq_q;
    ins_d    = ins_q;
    br_d     = br_q;
    ba_d     = ba_q;
    pi_d     = pi_q;
    sel_d    = sel_q;
    miso     = 8'hFF;
    refused  = 1'b0;
    job_kind = sfce_pkg::JOB_NONE;
    job_addr = ins_shift;
    buf_wr   = '0;

    // Load the fetched read byte into the top of the output queue
    if (resp.rd_valid) begin
      oq_d = {resp.rd_data, 24'h00_0000};
    end

    if (accept) begin
      case (op_i)
        sfce_pkg::OP_SELECT: begin
          sel_d = 1'b1;
          br_d  = 2'd0;
        end
        sfce_pkg::OP_XFER: begin
          // Deselected exchanges drive 0xFF and change nothing
          if (sel_q) begin
            miso  = oq_q[31:24];
            oq_d  = {oq_q[23:0], 8'h00};
            ins_d = ins_shift;
            if (ac_q != AC_IDLE && br_q != 2'd0) begin
              br_d = br_q - 2'd1;
              if (br_q == 2'd1) begin
                // Last byte of an address or data phase
                unique case (ac_q)
                  AC_WRSR: begin
                    bp_d  = ins_shift[4:2];
                    ac_d  = AC_IDLE;
                    ins_d = '0;
                  end
                  AC_READ: begin
                    job_kind = sfce_pkg::JOB_READ;
                    ba_d     = ins_shift + ADDR_BITS'(1);
                    ac_d     = AC_RDATA;
                    br_d     = 2'd1;
                  end
                  AC_FAST: begin
                    ba_d = ins_shift;
                    oq_d = '1;
                    ac_d = AC_RDATA;
                    br_d = 2'd1;
                  end
                  AC_RDATA: begin
                    job_kind = sfce_pkg::JOB_READ;
                    job_addr = ba_q;
                    ba_d     = ba_q + ADDR_BITS'(1);
                    br_d     = 2'd1;
                  end
                  AC_PP: begin
                    if (prot) begin
                      refused = 1'b1;
                      ac_d    = AC_IDLE;
                      ins_d   = '0;
                    end else begin
                      job_kind = sfce_pkg::JOB_PRESET;
                      ba_d     = ins_shift & ~PAGE_MASK;
                      pi_d     = ins_shift[PW-1:0];
                      ac_d     = AC_PDATA;
                      br_d     = 2'd1;
                    end
                  end
                  AC_PDATA: begin
                    buf_wr.en   = 1'b1;
                    buf_wr.idx  = pi_q;
                    buf_wr.data = ins_shift[7:0];
                    pi_d        = pi_q + PW'(1);
                    br_d        = 2'd1;
                  end
                  AC_SE: begin
                    job_kind = sfce_pkg::JOB_ERASE_SECTOR;
                    wel_d    = 1'b0;
                    ac_d     = AC_IDLE;
                    ins_d    = '0;
                  end
                  default: begin
                    ac_d  = AC_IDLE;
                    ins_d = '0;
                  end
                endcase
              end
            end else begin
              // Opcode byte
              unique case (mosi_byte_i)
                sfce_pkg::OPC_WREN: begin
                  wel_d = 1'b1;
                  ac_d  = AC_IDLE;
                  ins_d = '0;
                end
                sfce_pkg::OPC_WRDI: begin
                  wel_d = 1'b0;
                  ac_d  = AC_IDLE;
                  ins_d = '0;
                end
                sfce_pkg::OPC_RDID: begin
                  oq_d  = sfce_pkg::ID_WORD;
                  ac_d  = AC_IDLE;
                  ins_d = '0;
                end
                sfce_pkg::OPC_RDSR: begin
                  oq_d = {status_now, 24'h00_0000};
                  ac_d = AC_IDLE;
                end
                sfce_pkg::OPC_WRSR: begin
                  if (wel_q) begin
                    ac_d = AC_WRSR;
                    br_d = 2'd1;
                  end else begin
                    ac_d  = AC_IDLE;
                    ins_d = '0;
                  end
                  wel_d = 1'b0;
                end
                sfce_pkg::OPC_READ: begin
                  ac_d = AC_READ;
                  br_d = 2'd3;
                end
                sfce_pkg::OPC_FAST: begin
                  ac_d = AC_FAST;
                  br_d = 2'd3;
                end
                sfce_pkg::OPC_PP: begin
                  if (wel_q) begin
                    ac_d = AC_PP;
                    br_d = 2'd3;
                  end else begin
                    ac_d  = AC_IDLE;
                    ins_d = '0;
                  end
                end
                sfce_pkg::OPC_SE: begin
                  if (wel_q) begin
                    ac_d = AC_SE;
                    br_d = 2'd3;
                  end else begin
                    ac_d  = AC_IDLE;
                    ins_d = '0;
                  end
                  wel_d = 1'b0;
                end
                sfce_pkg::OPC_BE: begin
                  // Bulk erase needs no write enable latch
                  job_kind = sfce_pkg::JOB_ERASE_ALL;
                  wel_d    = 1'b0;
                  ac_d     = AC_IDLE;
                  ins_d    = '0;
                end
                sfce_pkg::OPC_RES: begin
                  oq_d  = sfce_pkg::RES_WORD;
                  ac_d  = AC_IDLE;
                  ins_d = '0;
                end
                default: begin
                  ac_d  = AC_IDLE;
                  ins_d = '0;
                end
              endcase
            end
          end
        end
        sfce_pkg::OP_RELEASE: begin
          // Commit a page program that reached its data phase
          if (ac_q == AC_PDATA) begin
            job_kind = sfce_pkg::JOB_COMMIT;
            job_addr = ba_q;
            wel_d    = 1'b0;
          end
          ac_d  = AC_IDLE;
          ins_d = '0;
          br_d  = 2'd0;
          sel_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_q        <= AC_IDLE;
      wel_q       <= 1'b0;
      bp_q        <= 3'd0;
      oq_q        <= '1;
      ins_q       <= '0;
      br_q        <= 2'd0;
      ba_q        <= '0;
      pi_q        <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ac_q  <= ac_d;
      wel_q <= wel_d;
      bp_q  <= bp_d;
      oq_q  <= oq_d;
      ins_q <= ins_d;
      br_q  <= br_d;
      ba_q  <= ba_d;
      pi_q  <= pi_d;
      sel_q <= sel_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; status reflects the state after this transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      miso_q    <= miso;
      status_q  <= {3'b000, bp_d, wel_d, 1'b0};
      refused_q <= refused;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign miso_byte_o     = miso_q;
  assign status_byte_o   = status_q;
  assign write_refused_o = refused_q;

  sfce_store #(
    .ADDR_BITS(ADDR_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_kind_i(job_kind),
    .job_addr_i(job_addr),
    .buf_wr_i  (buf_wr),
    .resp_o    (resp)
  );

  // Read data comes back only in the cycle after a read was launched
  `SFCE_ASSERT(a_rd_after_job, resp.rd_valid |-> $past(job_kind == sfce_pkg::JOB_READ), "read data without a read job")
  // Jobs are launched only into an idle store
  `SFCE_ASSERT_NEVER(a_job_when_busy, (job_kind != sfce_pkg::JOB_NONE) && resp.busy, "job launched while store busy")
  // A committed page always drops the write enable latch
  `SFCE_ASSERT(a_commit_clears_wel, (accept && op_i == sfce_pkg::OP_RELEASE && ac_q == AC_PDATA) |=> !wel_q, "latch left set after page commit")

endmodule
